@@ sv/act_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// act_pkg
// shared sizes and command codes of the trie engine
// ----------------------------------------------------------------------------
package act_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int KEY_W      = 8;
  localparam int OP_W       = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_BUILD  = 2'd2;
  localparam logic [OP_W-1:0] OP_MATCH  = 2'd3;

endpackage

@@ sv/aho_corasick_trie_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aho_corasick_trie_engine_top
// byte-keyed trie with failure links, one command per request
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on node_index_o and status_o, with done_o high for exactly one cycle,
// and must be captured then, as the receiver cannot stall it. Clear answers
// straight from idle. Insert runs a lookup (S_LK_A, S_LK_B, then S_LK_C per
// sibling scanned), then S_INS_W1 and S_INS_W2 when a node is created. Match
// runs the same lookup, plus S_FL_B per failure link followed. Build walks
// every node once, and per node runs a lookup like a match. The steps follow
// from the registered reads of the key, child, sibling, failure and queue
// memories, one read per memory per cycle.
// ----------------------------------------------------------------------------
module aho_corasick_trie_engine_top
  import act_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  symbol_i,
  input  logic              word_last_i,
  input  logic [NODE_W-1:0] from_state_i,
  output logic              done_o,
  output logic [NODE_W-1:0] node_index_o,
  output logic              status_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LK_A   = 4'd1;
  localparam logic [3:0] S_LK_B   = 4'd2;
  localparam logic [3:0] S_LK_C   = 4'd3;
  localparam logic [3:0] S_FL_B   = 4'd4;
  localparam logic [3:0] S_INS_W1 = 4'd5;
  localparam logic [3:0] S_INS_W2 = 4'd6;
  localparam logic [3:0] S_BQ_A   = 4'd7;
  localparam logic [3:0] S_BQ_B   = 4'd8;
  localparam logic [3:0] S_BQ_C   = 4'd9;
  localparam logic [3:0] S_BN_A   = 4'd10;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NODE_COUNT);

  // memories
  logic [KEY_W-1:0]  key_mem   [NODE_COUNT];
  logic [NODE_W-1:0] child_mem [NODE_COUNT];
  logic [NODE_W-1:0] sib_mem   [NODE_COUNT];
  logic [NODE_W-1:0] fail_mem  [NODE_COUNT];
  logic [NODE_W-1:0] queue_mem [NODE_COUNT];

  logic [KEY_W-1:0]  key_rd_q;
  logic [NODE_W-1:0] child_rd_q, sib_rd_q, fail_rd_q, queue_rd_q;

  logic              key_we, child_we, sib_we, fail_we, q_we;
  logic [NODE_W-1:0] key_wa, child_wa, sib_wa, fail_wa, q_wa;
  logic [KEY_W-1:0]  key_wd;
  logic [NODE_W-1:0] child_wd, sib_wd, fail_wd, q_wd;
  logic [NODE_W-1:0] child_ra, ks_ra, fail_ra, q_ra;

  // control and working registers
  logic [3:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [KEY_W-1:0]  k_q, k_d;
  logic              wl_q, wl_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [NODE_W-1:0] cursor_q, cursor_d;
  logic [NODE_W-1:0] root_child_q, root_child_d;
  logic [NODE_W-1:0] v_q, v_d;
  logic [NODE_W-1:0] c_q, c_d;
  logic              first_q, first_d;
  logic [NODE_W-1:0] new_q, new_d;
  logic [CNT_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  tail_q, tail_d;
  logic [NODE_W-1:0] top_q, top_d;
  logic [NODE_W-1:0] ftop_q, ftop_d;
  logic [NODE_W-1:0] nx_q, nx_d;
  logic [NODE_W-1:0] nsib_q, nsib_d;
  logic              done_q, done_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic              status_q, status_d;

  logic              lk_hit, lk_miss;
  logic [NODE_W-1:0] cand, res, pp;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    k_d          = k_q;
    wl_d         = wl_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    root_child_d = root_child_q;
    v_d          = v_q;
    c_d          = c_q;
    first_d      = first_q;
    new_d        = new_q;
    head_d       = head_q;
    tail_d       = tail_q;
    top_d        = top_q;
    ftop_d       = ftop_q;
    nx_d         = nx_q;
    nsib_d       = nsib_q;
    done_d       = 1'b0;
    node_d       = node_q;
    status_d     = status_q;
    key_we   = 1'b0;  key_wa   = '0;  key_wd   = '0;
    child_we = 1'b0;  child_wa = '0;  child_wd = '0;
    sib_we   = 1'b0;  sib_wa   = '0;  sib_wd   = '0;
    fail_we  = 1'b0;  fail_wa  = '0;  fail_wd  = '0;
    q_we     = 1'b0;  q_wa     = '0;  q_wd     = '0;
    child_ra = v_q;
    ks_ra    = c_q;
    fail_ra  = v_q;
    q_ra     = head_q[NODE_W-1:0];
    lk_hit   = 1'b0;
    lk_miss  = 1'b0;
    cand     = '0;
    res      = '0;
    pp       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = op_i;
          k_d      = symbol_i;
          wl_d     = word_last_i;
          status_d = 1'b0;
          unique case (op_i)
            OP_CLEAR: begin
              count_d      = CNT_W'(1);
              cursor_d     = '0;
              root_child_d = '0;
              node_d       = '0;
              done_d       = 1'b1;
            end
            OP_INSERT: begin
              v_d     = cursor_q;
              state_d = S_LK_A;
            end
            OP_BUILD: begin
              head_d  = '0;
              tail_d  = CNT_W'(1);
              q_we    = 1'b1;
              state_d = S_BQ_A;
            end
            default: begin
              if ({1'b0, from_state_i} >= count_q) begin
                node_d = '0;
                done_d = 1'b1;
              end else begin
                v_d     = from_state_i;
                state_d = S_LK_A;
              end
            end
          endcase
        end
      end
      S_LK_A: begin
        child_ra = v_q;
        state_d  = S_LK_B;
      end
      S_LK_B: begin
        cand    = (v_q == '0) ? root_child_q : child_rd_q;
        first_d = (cand == '0);
        if (cand == '0) begin
          lk_miss = 1'b1;
        end else begin
          ks_ra   = cand;
          c_d     = cand;
          state_d = S_LK_C;
        end
      end
      S_LK_C: begin
        if (key_rd_q == k_q) begin
          lk_hit = 1'b1;
        end else if (sib_rd_q == '0) begin
          lk_miss = 1'b1;
        end else begin
          ks_ra = sib_rd_q;
          c_d   = sib_rd_q;
        end
      end
      S_FL_B: begin
        v_d      = fail_rd_q;
        child_ra = fail_rd_q;
        state_d  = S_LK_B;
      end
      S_INS_W1: begin
        key_we   = 1'b1;  key_wa   = new_q;  key_wd   = k_q;
        child_we = 1'b1;  child_wa = new_q;
        sib_we   = 1'b1;  sib_wa   = new_q;
        fail_we  = 1'b1;  fail_wa  = new_q;
        count_d  = count_q + CNT_W'(1);
        state_d  = S_INS_W2;
      end
      S_INS_W2: begin
        if (first_q) begin
          if (v_q == '0) begin
            root_child_d = new_q;
          end else begin
            child_we = 1'b1;
            child_wa = v_q;
            child_wd = new_q;
          end
        end else begin
          sib_we = 1'b1;
          sib_wa = c_q;
          sib_wd = new_q;
        end
        node_d   = new_q;
        cursor_d = wl_q ? '0 : new_q;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      S_BQ_A: begin
        if (head_q >= tail_q) begin
          node_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          q_ra    = head_q[NODE_W-1:0];
          head_d  = head_q + CNT_W'(1);
          state_d = S_BQ_B;
        end
      end
      S_BQ_B: begin
        top_d    = queue_rd_q;
        child_ra = queue_rd_q;
        fail_ra  = queue_rd_q;
        state_d  = S_BQ_C;
      end
      S_BQ_C: begin
        ftop_d = (top_q == '0) ? '0 : fail_rd_q;
        cand   = (top_q == '0) ? root_child_q : child_rd_q;
        if (cand == '0) begin
          state_d = S_BQ_A;
        end else begin
          nx_d    = cand;
          ks_ra   = cand;
          state_d = S_BN_A;
        end
      end
      S_BN_A: begin
        k_d     = key_rd_q;
        nsib_d  = sib_rd_q;
        v_d     = ftop_q;
        state_d = S_LK_A;
      end
      default: state_d = S_IDLE;
    endcase

    // lookup finished
    if (lk_hit || lk_miss) begin
      if (op_q == OP_INSERT) begin
        if (lk_hit) begin
          node_d   = c_q;
          cursor_d = wl_q ? '0 : c_q;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (count_q == CNT_FULL) begin
          status_d = 1'b1;
          node_d   = v_q;
          cursor_d = wl_q ? '0 : v_q;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          new_d   = count_q[NODE_W-1:0];
          state_d = S_INS_W1;
        end
      end else if (lk_miss && v_q != '0) begin
        fail_ra = v_q;
        state_d = S_FL_B;
      end else begin
        res = lk_hit ? c_q : '0;
        if (op_q == OP_BUILD) begin
          pp      = (res == nx_q) ? '0 : res;
          fail_we = 1'b1;
          fail_wa = nx_q;
          fail_wd = pp;
          if (tail_q < CNT_FULL) begin
            q_we   = 1'b1;
            q_wa   = tail_q[NODE_W-1:0];
            q_wd   = nx_q;
            tail_d = tail_q + CNT_W'(1);
          end
          if (nsib_q == '0) begin
            state_d = S_BQ_A;
          end else begin
            nx_d    = nsib_q;
            ks_ra   = nsib_q;
            state_d = S_BN_A;
          end
        end else begin
          node_d  = res;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (sib_we) begin
      sib_mem[sib_wa] <= sib_wd;
    end
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    key_rd_q   <= key_mem[ks_ra];
    sib_rd_q   <= sib_mem[ks_ra];
    child_rd_q <= child_mem[child_ra];
    fail_rd_q  <= fail_mem[fail_ra];
    queue_rd_q <= queue_mem[q_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= CNT_W'(1);
      cursor_q     <= '0;
      root_child_q <= '0;
      done_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      cursor_q     <= cursor_d;
      root_child_q <= root_child_d;
      done_q       <= done_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    k_q      <= k_d;
    wl_q     <= wl_d;
    v_q      <= v_d;
    c_q      <= c_d;
    first_q  <= first_d;
    new_q    <= new_d;
    top_q    <= top_d;
    ftop_q   <= ftop_d;
    nx_q     <= nx_d;
    nsib_q   <= nsib_d;
    node_q   <= node_d;
    status_q <= status_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign node_index_o = node_q;
  assign status_o     = status_q;

endmodule
